FILE: hdl/swfr_pkg.sv
// Package: shared types and constants of the sliding-window frame-rate meter.
package swfr_pkg;

    // Payload widths fixed by the channel definitions
    localparam int TIME_W = 63;
    localparam int RATE_W = 33;
    localparam int FILL_OUT_W = 5;

    // One second in microseconds, scaled by 2^8 for the Q8 result
    localparam int US_Q8_W = 28;
    localparam logic [US_Q8_W-1:0] US_Q8 = 28'd256000000;

    // Largest rate that fits the result field
    localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_DONE
    } t_state;

    // Divider control and status
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: hdl/swfr_if.sv
// Interfaces: timestamp request channel and rate result channel.
interface swfr_in_if;
    logic                           valid;
    logic                           ready;
    logic [swfr_pkg::TIME_W-1:0]    frame_time_us;

    modport source (output valid, output frame_time_us, input ready);
    modport sink (input valid, input frame_time_us, output ready);
endinterface

interface swfr_out_if;
    logic                               valid;
    logic                               ready;
    logic [swfr_pkg::RATE_W-1:0]        frame_rate_q8;
    logic [swfr_pkg::FILL_OUT_W-1:0]    window_filled;

    modport source (output valid, output frame_rate_q8, output window_filled, input ready);
    modport sink (input valid, input frame_rate_q8, input window_filled, output ready);
endinterface

FILE: hdl/swfr_ring.sv
// Timestamp ring: one write port, one registered read port.
module swfr_ring #(
    parameter int DEPTH = 20,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [ADDR_W-1:0]               i_wr_addr,
    input  logic [swfr_pkg::TIME_W-1:0]     i_wr_data,
    input  logic [ADDR_W-1:0]               i_rd_addr,
    output logic [swfr_pkg::TIME_W-1:0]     o_rd_data
);

    logic [swfr_pkg::TIME_W-1:0] r_mem [DEPTH];
    logic [swfr_pkg::TIME_W-1:0] r_rd_data;

    // Store the new timestamp
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read the oldest timestamp, registered
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/swfr_div.sv
// Restoring divider: one quotient bit per cycle.
module swfr_div #(
    parameter int NUM_W = 33
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  swfr_pkg::t_div_ctl              i_ctl,
    input  logic [NUM_W-1:0]                i_dividend,
    input  logic [swfr_pkg::TIME_W-1:0]     i_divisor,
    output swfr_pkg::t_div_stat             o_stat,
    output logic [NUM_W-1:0]                o_quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int CMP_W = (NUM_W + 1 > swfr_pkg::TIME_W) ? NUM_W + 1 : swfr_pkg::TIME_W;

    logic [NUM_W-1:0]               r_quo;
    logic [NUM_W-1:0]               r_rem;
    logic [swfr_pkg::TIME_W-1:0]    r_dvs;
    logic [CNT_W-1:0]               r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [CMP_W-1:0]               trial;
    logic [CMP_W-1:0]               dvs_ext;
    logic [CMP_W-1:0]               diff;
    logic                           fits;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        trial   = CMP_W'({r_rem, r_quo[NUM_W-1]});
        dvs_ext = CMP_W'(r_dvs);
        diff    = trial - dvs_ext;
        fits    = (trial >= dvs_ext);
    end

    // Control: start, count down, flag completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_ctl.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: load operands, then one step per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.start && !r_busy) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? NUM_W'(diff) : NUM_W'(trial);
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

FILE: hdl/sliding_window_frame_rate.sv
// Top level: sliding-window frame-rate meter with ring, sequencer and divider.
//
// Usage: each request on i_frame carries one frame timestamp in microseconds.
// The block stores it in a ring of the last WINDOW timestamps and answers
// with one result on o_rate: frame_rate_q8 is frames per second in unsigned
// Q8, truncated, measured from the oldest stored stamp to the newest, and
// window_filled is the number of stamps in use (saturating at WINDOW).
// The rate is 0 until the second frame and whenever time stood still or went
// back; it saturates at the top of its 33-bit field.
// The rate is computed by one shared restoring divider that yields
// one quotient bit per cycle, 28 + clog2(WINDOW+1) bits (33 for WINDOW = 20).
// An item is stored and its oldest stamp read, then divided, then delivered;
// the first frame skips the divider. i_frame.ready is high only while the
// sequencer is idle, so one item is in work at a time.
// A finished result waits in the output register; the next request is taken
// meanwhile, and its result waits inside until the receiver takes the first.
// Reset (synchronous, active low) empties the window, sets the write slot
// and the last rate to zero, and drops any pending result; ring contents are
// not cleared, since a slot is only read after it was written.
module sliding_window_frame_rate #(
    parameter int WINDOW = 20
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    swfr_in_if.sink         i_frame,
    swfr_out_if.source      o_rate
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int NUM_W  = swfr_pkg::US_Q8_W + FILL_W;
    localparam int SAT_W  = (NUM_W > swfr_pkg::RATE_W) ? NUM_W : swfr_pkg::RATE_W;

    swfr_pkg::t_state                   r_state;
    swfr_pkg::t_state                   n_state;
    logic [SLOT_W-1:0]                  r_wslot;
    logic [FILL_W-1:0]                  r_fill;
    logic [swfr_pkg::TIME_W-1:0]        r_now;
    logic [swfr_pkg::RATE_W-1:0]        r_last;
    logic                               r_out_valid;
    logic [swfr_pkg::RATE_W-1:0]        r_out_rate;
    logic [swfr_pkg::FILL_OUT_W-1:0]    r_out_fill;

    logic                               accept;
    logic [SLOT_W-1:0]                  slot_next;
    logic [FILL_W-1:0]                  fill_inc;
    logic [SLOT_W-1:0]                  oldest_addr;
    logic [swfr_pkg::TIME_W-1:0]        oldest;
    logic                               span_pos;
    logic [swfr_pkg::TIME_W-1:0]        span;
    logic [NUM_W-1:0]                   numer;
    logic [NUM_W-1:0]                   quot;
    logic [SAT_W-1:0]                   quot_ext;
    logic [swfr_pkg::RATE_W-1:0]        quot_sat;
    swfr_pkg::t_div_ctl                 div_ctl;
    swfr_pkg::t_div_stat                div_stat;
    logic                               load_out;
    logic                               clr_last;
    logic                               set_last;

    // Advance the write slot and fill count on each accepted request, and find the oldest slot
    always_comb begin
        accept      = i_frame.valid && i_frame.ready;
        slot_next   = (r_wslot == SLOT_W'(WINDOW - 1)) ? '0 : r_wslot + SLOT_W'(1);
        fill_inc    = (r_fill == FILL_W'(WINDOW)) ? r_fill : r_fill + FILL_W'(1);
        oldest_addr = (fill_inc < FILL_W'(WINDOW)) ? '0 : slot_next;
    end

    swfr_ring #(
        .DEPTH      (WINDOW)
    ) u_ring (
        .i_clk      (i_clk),
        .i_we       (accept),
        .i_wr_addr  (r_wslot),
        .i_wr_data  (i_frame.frame_time_us),
        .i_rd_addr  (oldest_addr),
        .o_rd_data  (oldest)
    );

    // Span and scaled numerator for the divider
    always_comb begin
        span_pos = (r_now > oldest);
        span     = r_now - oldest;
        numer    = NUM_W'(swfr_pkg::US_Q8) * NUM_W'(r_fill - FILL_W'(1));
    end

    swfr_div #(
        .NUM_W      (NUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (numer),
        .i_divisor  (span),
        .o_stat     (div_stat),
        .o_quotient (quot)
    );

    // Saturate the quotient to the result field
    always_comb begin
        quot_ext = SAT_W'(quot);
        quot_sat = (quot_ext > SAT_W'(swfr_pkg::RATE_MAX)) ?
                   swfr_pkg::RATE_MAX : swfr_pkg::RATE_W'(quot_ext);
    end

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swfr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence one request: store, read oldest, divide, deliver
    always_comb begin
        n_state       = r_state;
        div_ctl.start = 1'b0;
        load_out      = 1'b0;
        clr_last      = 1'b0;
        set_last      = 1'b0;
        case (r_state)
            swfr_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (fill_inc > FILL_W'(1)) ? swfr_pkg::S_LOAD : swfr_pkg::S_DONE;
                end
            end
            swfr_pkg::S_LOAD: begin
                if (span_pos) begin
                    div_ctl.start = 1'b1;
                    n_state       = swfr_pkg::S_DIV;
                end else begin
                    clr_last = 1'b1;
                    n_state  = swfr_pkg::S_DONE;
                end
            end
            swfr_pkg::S_DIV: begin
                if (div_stat.done) begin
                    set_last = 1'b1;
                    n_state  = swfr_pkg::S_DONE;
                end
            end
            swfr_pkg::S_DONE: begin
                if (!r_out_valid || o_rate.ready) begin
                    load_out = 1'b1;
                    n_state  = swfr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = swfr_pkg::S_IDLE;
            end
        endcase
    end

    // Window bookkeeping and last rate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wslot <= '0;
            r_fill  <= '0;
            r_last  <= '0;
        end else begin
            if (accept) begin
                r_wslot <= slot_next;
                r_fill  <= fill_inc;
            end
            if (clr_last) begin
                r_last <= '0;
            end else if (set_last) begin
                r_last <= quot_sat;
            end
        end
    end

    // Latch the new timestamp
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now <= i_frame.frame_time_us;
        end
    end

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rate.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_rate <= r_last;
            r_out_fill <= swfr_pkg::FILL_OUT_W'(r_fill);
        end
    end

    assign i_frame.ready        = (r_state == swfr_pkg::S_IDLE);
    assign o_rate.valid         = r_out_valid;
    assign o_rate.frame_rate_q8 = r_out_rate;
    assign o_rate.window_filled = r_out_fill;

endmodule
